FILE: rtl/dual_channel_fir_with_prefill_assert.svh
// Assertion macros for the dual-channel FIR filter.
`ifndef DUAL_CHANNEL_FIR_WITH_PREFILL_ASSERT_SVH
`define DUAL_CHANNEL_FIR_WITH_PREFILL_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define DCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dcf_pkg.sv
// Package for the dual-channel FIR filter: defaults, command codes and sequencer states.
package dcf_pkg;

  localparam int TAPS_DEF        = 151;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 18;
  localparam int CMD_W           = 2;
  localparam int INDEX_W         = 8;

  // Command carried in tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_FILTER  = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_WRITE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_SAT
  } state_t;

endpackage

FILE: rtl/dual_channel_fir_with_prefill.sv
// Dual-channel (red / infrared) FIR filter with shared coefficients and history prefill.
//
// One input transfer carries a command in s_tuser: filter a sample pair, load one
// coefficient, or restart the history. Loads and restarts give no result. A filter
// transfer starts a multiply-accumulate pass that reads one tap per cycle from the history
// and coefficient memories; the input is ready again in the same cycle that its result
// becomes valid. The first filter transfer after reset or a restart first prefills every
// history slot with its samples. Both channels run in two lanes of one MAC pipeline under
// the same sequencer. The result is rounded half up and saturated, and waits in an output
// register, so the next transfer is taken while the result is still pending.
// Coefficients read as zero until loaded.
module dual_channel_fir_with_prefill #(
  parameter int TAPS        = dcf_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = dcf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = dcf_pkg::COEF_BITS_DEF,
  localparam int IN_W  = ((2 * SAMPLE_BITS + dcf_pkg::INDEX_W + COEF_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // red_sample, ir_sample, coef_index, coef_value, zero pad
  input  logic [IN_W-1:0]           s_tdata,
  // cmd
  input  logic [dcf_pkg::CMD_W-1:0] s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // red_out, ir_out, zero pad
  output logic [OUT_W-1:0]          m_tdata
);
  import dcf_pkg::*;

  localparam int AW    = $clog2(TAPS);
  localparam int FRAC  = COEF_BITS - 1;
  localparam int PW    = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W = PW + $clog2(TAPS);
  localparam int IR_LO = SAMPLE_BITS;
  localparam int IX_LO = 2 * SAMPLE_BITS;
  localparam int CV_LO = 2 * SAMPLE_BITS + INDEX_W;
  localparam logic [AW-1:0] LAST = AW'(TAPS - 1);
  localparam logic signed [ACC_W-1:0] RND_BIAS =
    {{(ACC_W - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  // Input fields
  logic                          in_xfer;
  logic [CMD_W-1:0]              in_cmd;
  logic signed [SAMPLE_BITS-1:0] in_red;
  logic signed [SAMPLE_BITS-1:0] in_ir;
  logic [INDEX_W-1:0]            in_idx;
  logic signed [COEF_BITS-1:0]   in_coef;

  assign in_xfer = s_tvalid && s_tready;
  assign in_cmd  = s_tuser;
  assign in_red  = s_tdata[SAMPLE_BITS-1:0];
  assign in_ir   = s_tdata[IR_LO +: SAMPLE_BITS];
  assign in_idx  = s_tdata[IX_LO +: INDEX_W];
  assign in_coef = s_tdata[CV_LO +: COEF_BITS];

  // Sequencer and datapath registers
  state_t state, state_next;
  logic                          primed;
  logic [AW-1:0]                 cnt;
  logic [AW-1:0]                 ptr;
  logic [AW-1:0]                 ptr_next;
  logic [AW-1:0]                 rd_addr;
  logic signed [SAMPLE_BITS-1:0] red_smp, ir_smp;
  logic                          rd_v, mul_v;
  logic signed [SAMPLE_BITS-1:0] red_rd, ir_rd;
  logic signed [COEF_BITS-1:0]   coef_rd;
  logic                          coef_hit;
  logic signed [COEF_BITS-1:0]   coef_eff;
  logic signed [PW-1:0]          prod_red, prod_ir;
  logic signed [ACC_W-1:0]       acc_red, acc_ir;
  logic signed [ACC_W-1:0]       rnd_red, rnd_ir;
  logic [TAPS-1:0]               coef_vld;

  // Control from the sequencer
  logic          hist_we;
  logic [AW-1:0] hist_waddr;
  logic          issue;
  logic          out_free;

  // Memories
  logic signed [SAMPLE_BITS-1:0] red_mem [TAPS];
  logic signed [SAMPLE_BITS-1:0] ir_mem  [TAPS];
  logic signed [COEF_BITS-1:0]   tap_mem [TAPS];

  assign ptr_next = (ptr == LAST) ? '0 : ptr + AW'(1);
  assign out_free = !m_tvalid || m_tready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    hist_we    = 1'b0;
    hist_waddr = cnt;
    issue      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && in_cmd == CMD_FILTER) begin
          state_next = primed ? ST_WRITE : ST_FILL;
        end
      end
      ST_FILL: begin
        hist_we = 1'b1;
        if (cnt == LAST) begin
          state_next = ST_MAC;
        end
      end
      ST_WRITE: begin
        hist_we    = 1'b1;
        hist_waddr = ptr_next;
        state_next = ST_MAC;
      end
      ST_MAC: begin
        issue = 1'b1;
        if (cnt == LAST) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v && !mul_v) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_next = ST_SAT;
      end
      ST_SAT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers: tap counter, newest-slot pointer, prefill flag, valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      ptr      <= '0;
      primed   <= 1'b0;
      coef_vld <= '0;
      rd_v     <= 1'b0;
      mul_v    <= 1'b0;
    end else begin
      rd_v  <= issue;
      mul_v <= rd_v;
      if ((state == ST_FILL || state == ST_MAC) && cnt != LAST) begin
        cnt <= cnt + AW'(1);
      end else begin
        cnt <= '0;
      end
      if (state == ST_WRITE) begin
        ptr <= ptr_next;
      end
      if (state == ST_FILL) begin
        primed <= 1'b1;
      end
      if (in_xfer && in_cmd == CMD_RESTART) begin
        primed <= 1'b0;
      end
      if (in_xfer && in_cmd == CMD_LOAD && {1'b0, in_idx} < (INDEX_W + 1)'(TAPS)) begin
        coef_vld[in_idx[AW-1:0]] <= 1'b1;
      end
    end
  end

  // Sample capture and read address walk (newest to oldest)
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      red_smp <= in_red;
      ir_smp  <= in_ir;
    end
    if (state == ST_WRITE) begin
      rd_addr <= ptr_next;
    end else if (state == ST_FILL) begin
      rd_addr <= ptr;
    end else if (issue) begin
      rd_addr <= (rd_addr == '0) ? LAST : rd_addr - AW'(1);
    end
  end

  // History memories
  always_ff @(posedge clk) begin
    if (hist_we) begin
      red_mem[hist_waddr] <= red_smp;
      ir_mem[hist_waddr]  <= ir_smp;
    end
    red_rd <= red_mem[rd_addr];
    ir_rd  <= ir_mem[rd_addr];
  end

  // Coefficient memory
  always_ff @(posedge clk) begin
    if (in_xfer && in_cmd == CMD_LOAD && {1'b0, in_idx} < (INDEX_W + 1)'(TAPS)) begin
      tap_mem[in_idx[AW-1:0]] <= in_coef;
    end
    coef_rd  <= tap_mem[cnt];
    coef_hit <= coef_vld[cnt];
  end

  assign coef_eff = coef_hit ? coef_rd : '0;

  // Multiply and accumulate lanes
  always_ff @(posedge clk) begin
    prod_red <= red_rd * coef_eff;
    prod_ir  <= ir_rd * coef_eff;
    if (state == ST_FILL || state == ST_WRITE) begin
      acc_red <= '0;
      acc_ir  <= '0;
    end else if (mul_v) begin
      acc_red <= acc_red + ACC_W'(prod_red);
      acc_ir  <= acc_ir + ACC_W'(prod_ir);
    end
    // Round half up, floor shift
    if (state == ST_ROUND) begin
      rnd_red <= (acc_red + RND_BIAS) >>> FRAC;
      rnd_ir  <= (acc_ir + RND_BIAS) >>> FRAC;
    end
  end

  // Saturate to the sample range
  function automatic logic [SAMPLE_BITS-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end
    return c[SAMPLE_BITS-1:0];
  endfunction

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_SAT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SAT && out_free) begin
      m_tdata <= OUT_W'({sat(rnd_ir), sat(rnd_red)});
    end
  end

  // Checks
  `include "dual_channel_fir_with_prefill_assert.svh"

  `DCF_ASSERT_NEXT(a_filter_starts, in_xfer && in_cmd == CMD_FILTER, state == ST_FILL || state == ST_WRITE, "filter transfer did not start a pass")
  `DCF_ASSERT_NOW(a_mac_primed, state == ST_MAC, primed, "MAC pass on unprimed history")
  `DCF_ASSERT_NOW(a_round_drained, state == ST_ROUND, !rd_v && !mul_v, "rounding before the MAC pipeline drained")
  `DCF_ASSERT_NEXT(a_result_held, state == ST_SAT && m_tvalid && !m_tready, state == ST_SAT && m_tvalid, "pending result overwritten")

endmodule
